[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/uart_tx_pkg.sv]
// ----------------------------------------------------------------------------
// uart_tx_pkg
// constants and types used by the uart transmitter
// ----------------------------------------------------------------------------
package uart_tx_pkg;

  localparam int FifoDepth = 64;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int DataBits  = 8;
  localparam int BitIdxW   = 4;
  localparam int SpaceW    = 7;

  typedef enum logic {
    OpTick = 1'b0,
    OpPush = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhData = 3'b010,
    PhStop = 3'b100
  } phase_e;

endpackage

[rtl/uart_tx_in_if.sv]
// ----------------------------------------------------------------------------
// uart_tx_in_if
// item channel into the transmitter: bit tick or byte push
// ----------------------------------------------------------------------------
interface uart_tx_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

[rtl/uart_tx_out_if.sv]
// ----------------------------------------------------------------------------
// uart_tx_out_if
// result channel out of the transmitter: line level and fifo status
// ----------------------------------------------------------------------------
interface uart_tx_out_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic       push_accepted;
  logic       idle;
  logic [6:0] space_remaining;

  modport source (output valid, output line_level, output push_accepted,
                  output idle, output space_remaining, input ready);
  modport sink (input valid, input line_level, input push_accepted,
                input idle, input space_remaining, output ready);
endinterface

[rtl/uart_tx_cfg_if.sv]
// ----------------------------------------------------------------------------
// uart_tx_cfg_if
// configuration write channel carrying the enable register
// ----------------------------------------------------------------------------
interface uart_tx_cfg_if;
  logic valid;
  logic ready;
  logic enabled;

  modport source (output valid, output enabled, input ready);
  modport sink (input valid, input enabled, output ready);
endinterface

[rtl/uart_tx_with_fifo.sv]
// ----------------------------------------------------------------------------
// uart_tx_with_fifo
// 8n1 serial transmitter fed by a byte fifo, advanced by bit ticks
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items: opcode tick advances the serial frame by one bit,
//   opcode push stores data_byte in the 64-entry fifo while enabled.
//   out_o returns exactly one result per item: line level, push status,
//   idle flag and free fifo entries after that item.
//   cfg_i writes the enable bit; it is always ready.
// Timing and throughput:
//   a result is registered and appears in the cycle after its item transfer;
//   one item per cycle is taken as long as out_o is drained. The fifo is a
//   single synchronous ram (one write port, one read port); a popped byte
//   lands in the ram read register in the cycle after the pop and is used
//   from there by the following tick.
// Reset:
//   line at mark, fifo empty, transmitter idle, pushes disabled. The ram
//   content is not cleared and needs no clearing pass.
// Stall:
//   while a result waits on out_o, in_i ready drops; a result taken in
//   the same cycle frees the register for the next item.
// ----------------------------------------------------------------------------
module uart_tx_with_fifo
  import uart_tx_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  uart_tx_in_if.sink    in_i,
  uart_tx_out_if.source out_o,
  uart_tx_cfg_if.sink   cfg_i
);

  `include "assert_macros.svh"

  logic [7:0] mem_q [FifoDepth];
  logic [7:0] rd_data_q;

  logic               enabled_q;
  logic [PtrW-1:0]    rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CntW-1:0]    fill_q, fill_d;
  phase_e             phase_q, phase_d;
  logic [7:0]         shift_q, shift_d;
  logic               pend_q, pend_d;
  logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
  logic               line_q, line_d;

  logic               out_valid_q;
  logic               out_line_q, out_acc_q, out_idle_q;
  logic [SpaceW-1:0]  out_space_q;

  logic              in_fire;
  logic              do_push, do_pop;
  logic [7:0]        eff_shift;
  logic [31:0]       space_full;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // popped byte sits in the ram read register until the next item uses it
  assign eff_shift = pend_q ? rd_data_q : shift_q;

  always_comb begin
    rptr_d    = rptr_q;
    wptr_d    = wptr_q;
    fill_d    = fill_q;
    phase_d   = phase_q;
    shift_d   = shift_q;
    pend_d    = pend_q;
    bit_idx_d = bit_idx_q;
    line_d    = line_q;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    if (in_fire) begin
      shift_d = eff_shift;
      pend_d  = 1'b0;
      if (op_e'(in_i.opcode) == OpPush) begin
        if (enabled_q && (fill_q < CntW'(FifoDepth))) begin
          do_push = 1'b1;
          wptr_d  = (wptr_q == PtrW'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
          fill_d  = fill_q + 1'b1;
        end
      end else begin
        unique case (phase_q)
          PhIdle: begin
            if (fill_q != '0) begin
              do_pop    = 1'b1;
              pend_d    = 1'b1;
              line_d    = 1'b0;
              rptr_d    = (rptr_q == PtrW'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
              fill_d    = fill_q - 1'b1;
              bit_idx_d = BitIdxW'(1);
              phase_d   = PhData;
            end
          end
          PhData: begin
            line_d = eff_shift[0];
            if (bit_idx_q >= BitIdxW'(DataBits)) begin
              phase_d = PhStop;
            end else begin
              bit_idx_d = bit_idx_q + 1'b1;
              shift_d   = eff_shift >> 1;
            end
          end
          PhStop: begin
            line_d  = 1'b1;
            phase_d = PhIdle;
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end
  end

  assign space_full = 32'(FifoDepth) - 32'(fill_d);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= in_i.data_byte;
    end
    if (do_pop) begin
      rd_data_q <= mem_q[rptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      rptr_q      <= '0;
      wptr_q      <= '0;
      fill_q      <= '0;
      phase_q     <= PhIdle;
      shift_q     <= '0;
      pend_q      <= 1'b0;
      bit_idx_q   <= '0;
      line_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        enabled_q <= cfg_i.enabled;
      end
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      fill_q      <= fill_d;
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      pend_q      <= pend_d;
      bit_idx_q   <= bit_idx_d;
      line_q      <= line_d;
      out_valid_q <= in_fire || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_line_q  <= line_d;
      out_acc_q   <= do_push;
      out_idle_q  <= (phase_d == PhIdle) && (fill_d == '0);
      out_space_q <= space_full[SpaceW-1:0];
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.line_level      = out_line_q;
  assign out_o.push_accepted   = out_acc_q;
  assign out_o.idle            = out_idle_q;
  assign out_o.space_remaining = out_space_q;

  `ASSERT_ALWAYS(a_fill_bound, fill_q <= CntW'(FifoDepth), "fifo fill above depth")
  `ASSERT_ALWAYS(a_pend_in_data, !pend_q || phase_q == PhData,
                 "pending read byte outside data phase")
  `ASSERT_NEXT(a_result_follows, in_fire, out_valid_q, "item transfer without result")
  `ASSERT_NEXT(a_pop_line_low, do_pop, !line_q && pend_q, "start bit missing after pop")

endmodule
